// File: sv/pal_pkg.sv
`default_nettype none

package pal_pkg;

  // Default geometry of the list storage.
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int WORD_BITS_DEF   = 32;

  // Index width that covers positions and counts for up to 256 entries.
  localparam int IDX_BITS = 9;

  // Capacity register.
  localparam int               CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef logic [IDX_BITS-1:0] idx_t;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_GET    = 2'd1,
    FN_DELETE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_e;

  // Status codes carried by a response.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Command broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic do_ins;
    logic do_del;
    idx_t pos;
    idx_t count;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: sv/pal_req_if.sv
`default_nettype none

// Request channel: operation, position and word to insert.
interface pal_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  position;
  logic [31:0] write_value;

  modport source (output valid, func, position, write_value, input ready);
  modport sink   (input valid, func, position, write_value, output ready);
endinterface

`default_nettype wire

// File: sv/pal_rsp_if.sv
`default_nettype none

// Response channel: word read, status and entry count.
interface pal_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// File: sv/positional_array_list.sv
// Ordered list of words with positional insert, get, delete and clear.
// The entries live in a row of cells; on insert every later cell takes its
// lower neighbor's word and on delete its upper neighbor's word, all in the
// same clock edge, so one request is accepted per cycle unless the output
// stalls, and its response appears in the output register on the following
// cycle. The limit on rate is the update of the cell row together with the
// OR reduction that reads the addressed cell. A full response register
// stalls requests only until the response is taken. The capacity register
// (reset 16, clamped to MAX_ENTRIES) may be written only while no request
// is pending. Cell contents are not reset; the entry count is.
`default_nettype none

module positional_array_list #(
  parameter int MAX_ENTRIES = pal_pkg::MAX_ENTRIES_DEF,
  parameter int WORD_BITS   = pal_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  pal_req_if.sink                            req,
  pal_rsp_if.source                          rsp,
  input  wire logic                          cfg_we_i,
  input  wire logic [pal_pkg::CAP_BITS-1:0]  cfg_data_i
);

  pal_pkg::cell_cmd_t   cmd;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] words     [MAX_ENTRIES];
  logic [WORD_BITS-1:0] hit_words [MAX_ENTRIES];

  pal_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WORD_BITS   (WORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .rd_word_i  (rd_word),
    .new_word_o (new_word),
    .cmd_o      (cmd)
  );

  // Row of cells, each linked to both neighbors.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_word, right_word;
    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_inner_l
      assign left_word = words[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_r
      assign right_word = words[g+1];
    end

    pal_cell #(
      .IDX       (g),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .new_word_i   (new_word),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (words[g]),
      .hit_word_o   (hit_words[g])
    );
  end

  // Only the addressed cell offers a nonzero word, so an OR selects it.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_word = rd_word | hit_words[i];
    end
  end

endmodule

`default_nettype wire

// File: sv/pal_cell.sv
`default_nettype none

module pal_cell #(
  parameter int IDX       = 0,
  parameter int WORD_BITS = pal_pkg::WORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire pal_pkg::cell_cmd_t    cmd_i,
  input  wire logic [WORD_BITS-1:0]  new_word_i,
  input  wire logic [WORD_BITS-1:0]  left_word_i,
  input  wire logic [WORD_BITS-1:0]  right_word_i,
  output logic      [WORD_BITS-1:0]  word_o,
  output logic      [WORD_BITS-1:0]  hit_word_o
);

  localparam pal_pkg::idx_t MY     = pal_pkg::idx_t'(IDX);
  localparam pal_pkg::idx_t MY_NXT = pal_pkg::idx_t'(IDX + 1);

  logic [WORD_BITS-1:0] word_q, word_d;

  // Insert loads the new word at its position and moves later entries up;
  // delete pulls later entries down over the removed one.
  always_comb begin
    word_d = word_q;
    if (cmd_i.do_ins) begin
      if (MY == cmd_i.pos) begin
        word_d = new_word_i;
      end else if (MY > cmd_i.pos && MY <= cmd_i.count) begin
        word_d = left_word_i;
      end
    end else if (cmd_i.do_del) begin
      if (MY >= cmd_i.pos && MY_NXT < cmd_i.count) begin
        word_d = right_word_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  // The addressed cell offers its old word to the read reduction.
  assign hit_word_o = (MY == cmd_i.pos) ? word_q : '0;

endmodule

`default_nettype wire

// File: sv/pal_ctrl.sv
`default_nettype none

module pal_ctrl #(
  parameter int MAX_ENTRIES = pal_pkg::MAX_ENTRIES_DEF,
  parameter int WORD_BITS   = pal_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  pal_req_if.sink                            req,
  pal_rsp_if.source                          rsp,
  input  wire logic                          cfg_we_i,
  input  wire logic [pal_pkg::CAP_BITS-1:0]  cfg_data_i,
  input  wire logic [WORD_BITS-1:0]          rd_word_i,
  output logic      [WORD_BITS-1:0]          new_word_o,
  output pal_pkg::cell_cmd_t                 cmd_o
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = (CW > 8) ? CW : 8;

  logic [CW-1:0]                count_q, count_d;
  logic [pal_pkg::CAP_BITS-1:0] cap_q;
  logic                         rsp_valid_q;
  logic [31:0]                  rsp_value_q;
  pal_pkg::status_e             rsp_status_q;
  logic [4:0]                   rsp_count_q;

  logic [KW-1:0]    count_k, cap_k, max_k, usable_k, pos_k;
  logic             full, out_of_range, accept;
  pal_pkg::func_e   func;
  pal_pkg::status_e status_d;
  logic [31:0]      value_d;

  assign accept  = req.valid && req.ready;
  assign func    = pal_pkg::func_e'(req.func);
  assign count_k = KW'(count_q);
  assign cap_k   = KW'(cap_q);
  assign max_k   = KW'(MAX_ENTRIES);
  assign pos_k   = KW'(req.position);

  // Capacity above the built depth saturates to the depth.
  assign usable_k     = (cap_k > max_k) ? max_k : cap_k;
  assign full         = count_k >= usable_k;
  assign out_of_range = pos_k >= count_k;

  // Decode the request into a cell command, the next count and a response.
  always_comb begin
    cmd_o        = '0;
    cmd_o.count  = pal_pkg::idx_t'(count_q);
    cmd_o.pos    = pal_pkg::idx_t'(pos_k);
    count_d      = count_q;
    status_d     = pal_pkg::ST_OK;
    value_d      = '0;
    unique case (func)
      pal_pkg::FN_INSERT: begin
        if (full) begin
          status_d = pal_pkg::ST_FULL;
        end else begin
          cmd_o.do_ins = accept;
          if (out_of_range) begin
            cmd_o.pos = pal_pkg::idx_t'(count_q);
          end
          count_d = count_q + CW'(1);
        end
      end
      pal_pkg::FN_GET: begin
        if (out_of_range) begin
          status_d = pal_pkg::ST_RANGE;
        end else begin
          value_d = 32'(rd_word_i);
        end
      end
      pal_pkg::FN_DELETE: begin
        if (out_of_range) begin
          status_d = pal_pkg::ST_RANGE;
        end else begin
          cmd_o.do_del = accept;
          value_d      = 32'(rd_word_i);
          count_d      = count_q - CW'(1);
        end
      end
      pal_pkg::FN_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign new_word_o = WORD_BITS'(req.write_value);

  // A new request is taken whenever the response register is free or drains.
  assign req.ready = !rsp_valid_q || rsp.ready;

  // Count, capacity and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= pal_pkg::CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_value_q  <= value_d;
      rsp_status_q <= status_d;
      rsp_count_q  <= 5'(count_d);
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.read_value  = rsp_value_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.entry_count = rsp_count_q;

endmodule

`default_nettype wire

// File: sv/pal_checker.sv
`default_nettype none

module pal_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic [1:0]  req_func_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [31:0] rsp_read_value_i,
  input wire logic [1:0]  rsp_status_i,
  input wire logic [4:0]  rsp_entry_count_i
);

  // Every accepted request has its response ready on the next cycle.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> rsp_valid_i)
    else $error("no response after an accepted request");

  // A clear leaves an empty list and reports success.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && req_func_i == pal_pkg::FN_CLEAR) |=>
    (rsp_entry_count_i == 5'd0 && rsp_status_i == pal_pkg::ST_OK))
    else $error("clear did not empty the list");

  // A refused request returns no data.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i != pal_pkg::ST_OK) |-> rsp_read_value_i == 32'd0)
    else $error("refused request returned data");

  // A stalled response stays presented.
  a_rsp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped while stalled");

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .req_func_i        (req.func),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_read_value_i  (rsp.read_value),
  .rsp_status_i      (rsp.status),
  .rsp_entry_count_i (rsp.entry_count)
);

`default_nettype wire

// File: tb/sv/pal_list_checker.sv
module pal_list_checker #(
  parameter int MAX_ENTRIES = pal_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  pal_req_if                                req_mon,
  pal_rsp_if                                rsp_mon,
  input  wire logic                         cfg_we_i,
  input  wire logic [pal_pkg::CAP_BITS-1:0] cfg_data_i,
  output int                                mismatch_cnt_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                full_seen_o,
  output int                                range_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One response as the block should deliver it.
  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } list_rsp_t;

  // Shadow copy of the list, its length and the capacity register.
  logic [31:0]                  list_words [MAX_ENTRIES];
  int                           list_len;
  logic [pal_pkg::CAP_BITS-1:0] cap_shadow;

  // Responses still owed by the block, oldest first.
  list_rsp_t expected_rsp_q [$];
  list_rsp_t got_rsp;
  list_rsp_t want_rsp;

  // Applies one request to the shadow list and returns the response it earns.
  function automatic list_rsp_t apply_list_op(pal_pkg::func_e op, logic [7:0] pos,
                                              logic [31:0] word);
    list_rsp_t r;
    int        usable;
    int        at;
    r.read_value  = '0;
    r.status      = pal_pkg::ST_OK;
    r.entry_count = '0;
    usable = (int'(cap_shadow) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_shadow);
    case (op)
      pal_pkg::FN_INSERT: begin
        if (list_len >= usable) begin
          r.status = pal_pkg::ST_FULL;
        end else begin
          // A position past the end appends.
          at = (int'(pos) > list_len) ? list_len : int'(pos);
          for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = word;
          list_len++;
        end
      end
      pal_pkg::FN_GET: begin
        if (int'(pos) >= list_len) r.status = pal_pkg::ST_RANGE;
        else r.read_value = list_words[pos];
      end
      pal_pkg::FN_DELETE: begin
        if (int'(pos) >= list_len) begin
          r.status = pal_pkg::ST_RANGE;
        end else begin
          r.read_value = list_words[pos];
          for (int i = int'(pos) + 1; i < list_len; i++) list_words[i-1] = list_words[i];
          list_len--;
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.entry_count = 5'(list_len);
    return r;
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic note_mismatch(string what, list_rsp_t want, list_rsp_t got);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= 10) begin
      $display("%0d ns: %s: expected value %h status %0d count %0d,",
               $time, what, want.read_value, want.status, want.entry_count);
      $display("    got value %h status %0d count %0d",
               got.read_value, got.status, got.entry_count);
    end
  endtask

  // Responses are retired before new requests are predicted, since a response
  // taken at an edge always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len       = 0;
      cap_shadow     = pal_pkg::CAP_RESET;
      expected_rsp_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
      checked_o      = 0;
      full_seen_o    = 0;
      range_seen_o   = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_rsp.read_value  = rsp_mon.read_value;
        got_rsp.status      = rsp_mon.status;
        got_rsp.entry_count = rsp_mon.entry_count;
        if (expected_rsp_q.size() == 0) begin
          note_mismatch("response with no request outstanding", '0, got_rsp);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          checked_o++;
          if (want_rsp.status == pal_pkg::ST_FULL) full_seen_o++;
          if (want_rsp.status == pal_pkg::ST_RANGE) range_seen_o++;
          if (got_rsp.read_value !== want_rsp.read_value ||
              got_rsp.status !== want_rsp.status ||
              got_rsp.entry_count !== want_rsp.entry_count) begin
            note_mismatch("response mismatch", want_rsp, got_rsp);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_rsp_q.push_back(apply_list_op(pal_pkg::func_e'(req_mon.func),
                                               req_mon.position, req_mon.write_value));
      end
      if (cfg_we_i) begin
        cap_shadow = cfg_data_i;
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 80;
  localparam int RANDOM_PHASES = 10;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [pal_pkg::CAP_BITS-1:0] cfg_data;

  int mismatches;
  int pending;
  int checked;
  int full_seen;
  int range_seen;

  // Stimulus controls shared by the sender and the receiver, and run counters.
  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  int hold_offs_done = 0;
  int cap_writes = 0;
  int sent_count = 0;

  logic [pal_pkg::CAP_BITS-1:0] phase_caps [RANDOM_PHASES] =
    '{5'd16, 5'd5, 5'd1, 5'd31, 5'd2, 5'd0, 5'd16, 5'd9, 5'd16, 5'd12};

  pal_req_if req_if ();
  pal_rsp_if rsp_if ();

  positional_array_list uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  pal_list_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_seen_o    (full_seen),
    .range_seen_o   (range_seen)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one request, after a random gap when gaps are enabled, and waits until it is taken.
  task automatic send_request(pal_pkg::func_e op, logic [7:0] pos, logic [31:0] word);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= op;
    req_if.position    <= pos;
    req_if.write_value <= word;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sent_count++;
  endtask

  // Draws a request biased toward positions near the live part of the list.
  task automatic send_random_request();
    pal_pkg::func_e op;
    logic [7:0]     pos;
    logic [31:0]    word;
    int             roll;
    roll = $urandom_range(0, 99);
    if (roll < 36) op = pal_pkg::FN_INSERT;
    else if (roll < 66) op = pal_pkg::FN_GET;
    else if (roll < 96) op = pal_pkg::FN_DELETE;
    else op = pal_pkg::FN_CLEAR;
    roll = $urandom_range(0, 9);
    if (roll == 0) pos = 8'($urandom_range(0, 255));
    else if (roll == 1) pos = 8'hFF;
    else pos = 8'($urandom_range(0, 17));
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      word = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: word = '0;
        1: word = '1;
        2: word = 32'h1 << $urandom_range(0, 31);
        default: word = ~(32'h1 << $urandom_range(0, 31));
      endcase
    end
    send_request(op, pos, word);
  endtask

  // Waits until every response is back, then writes the capacity register.
  task automatic set_capacity(logic [pal_pkg::CAP_BITS-1:0] cap);
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cap_writes++;
  endtask

  // Response side: random back-pressure plus the occasional long hold-off.
  initial begin
    int wait_cycles;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off_req) begin
        wait_cycles = HOLD_CYCLES;
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else begin
        wait_cycles = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (wait_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Request side: reset, directed cases, random phases, then the verdict.
  initial begin
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_data           <= pal_pkg::CAP_RESET;
    req_if.valid       <= 1'b0;
    req_if.func        <= pal_pkg::FN_INSERT;
    req_if.position    <= '0;
    req_if.write_value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every read or removal is out of range.
    send_request(pal_pkg::FN_GET, 8'd0, 32'h0);
    send_request(pal_pkg::FN_DELETE, 8'd0, 32'h0);
    send_request(pal_pkg::FN_GET, 8'd255, 32'h0);
    // Inserts at the end, past the end, at the front and in the middle.
    send_request(pal_pkg::FN_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_request(pal_pkg::FN_INSERT, 8'd0, 32'h0000_0000);
    send_request(pal_pkg::FN_INSERT, 8'd1, 32'hA5A5_A5A5);
    send_request(pal_pkg::FN_INSERT, 8'd3, 32'h5A5A_5A5A);
    send_request(pal_pkg::FN_INSERT, 8'd200, 32'h8000_0001);
    send_request(pal_pkg::FN_GET, 8'd0, 32'h0);
    send_request(pal_pkg::FN_GET, 8'd4, 32'h0);
    send_request(pal_pkg::FN_GET, 8'd5, 32'h0);
    send_request(pal_pkg::FN_GET, 8'd255, 32'h0);
    // Deletes in the middle, out of range, at the front and at the end.
    send_request(pal_pkg::FN_DELETE, 8'd2, 32'h0);
    send_request(pal_pkg::FN_DELETE, 8'd255, 32'h0);
    send_request(pal_pkg::FN_DELETE, 8'd0, 32'h0);
    send_request(pal_pkg::FN_DELETE, 8'd2, 32'h0);
    send_request(pal_pkg::FN_CLEAR, 8'd0, 32'h0);
    send_request(pal_pkg::FN_GET, 8'd0, 32'h0);
    send_request(pal_pkg::FN_CLEAR, 8'd7, 32'h0);

    // Capacity of one: the second insert is refused.
    set_capacity(5'd1);
    send_request(pal_pkg::FN_INSERT, 8'd0, 32'h1234_5678);
    send_request(pal_pkg::FN_INSERT, 8'd0, 32'h8765_4321);
    send_request(pal_pkg::FN_DELETE, 8'd0, 32'h0);

    // Zero capacity keeps the list full for inserts.
    set_capacity(5'd0);
    send_request(pal_pkg::FN_INSERT, 8'd0, 32'hDEAD_BEEF);
    send_request(pal_pkg::FN_GET, 8'd0, 32'h0);

    // Oversized capacity saturates to the storage depth.
    set_capacity(5'd31);
    repeat (pal_pkg::MAX_ENTRIES_DEF) begin
      send_request(pal_pkg::FN_INSERT, 8'($urandom_range(0, 16)), $urandom);
    end
    send_request(pal_pkg::FN_INSERT, 8'd0, 32'hCAFE_F00D);
    send_request(pal_pkg::FN_GET, 8'd15, 32'h0);

    // Capacity lowered below the count: inserts refused, removals still work.
    set_capacity(5'd4);
    send_request(pal_pkg::FN_INSERT, 8'd3, 32'h0BAD_CAFE);
    send_request(pal_pkg::FN_DELETE, 8'd15, 32'h0);
    send_request(pal_pkg::FN_DELETE, 8'd0, 32'h0);
    send_request(pal_pkg::FN_CLEAR, 8'd0, 32'h0);

    // Random phases, each under its own capacity setting.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_capacity(phase_caps[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if ((ph == 2 || ph == 6) && n == 20) hold_off_req = 1'b1;
        send_random_request();
      end
    end

    // Drain, let the pipeline settle, and give the verdict.
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    $display("Sent %0d requests under %0d capacity writes; %0d responses checked.",
             sent_count, cap_writes, checked);
    $display("Saw %0d full refusals, %0d out-of-range responses and %0d long output stalls.",
             full_seen, range_seen, hold_offs_done);
    if (mismatches == 0) begin
      $display("positional_array_list regression: pass");
    end else begin
      $display("positional_array_list regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("positional_array_list regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
sv/pal_pkg.sv
sv/pal_req_if.sv
sv/pal_rsp_if.sv
sv/pal_cell.sv
sv/pal_ctrl.sv
sv/positional_array_list.sv
sv/pal_checker.sv
tb/sv/pal_list_checker.sv
tb/sv/tb_top.sv
